[src/assert_macros.svh]
// Concurrent assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

[src/ofsc_pkg.sv]
`default_nettype none

package ofsc_pkg;

  localparam int LIGHT_BITS = 10;
  localparam int LIMIT_W    = 12;
  localparam int TEMP_W     = 6;
  localparam int DUTY_W     = 8;
  localparam int PCT_W      = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = 12'd800;
  localparam logic [LIMIT_W-1:0] IDLE_MAX       = 12'd4095;
  localparam logic [TEMP_W-1:0]  SET_POINT_RST  = 6'd20;
  localparam logic [TEMP_W-1:0]  SET_POINT_MAX  = 6'd63;

  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_OFF  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RAISE = 2'd1,
    OP_LOWER = 2'd2,
    OP_OFF   = 2'd3
  } op_t;

  // register index 0 in the word-address field
  localparam logic REG_IDLE_LIMIT = 1'b0;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [PCT_W-1:0]  pct;
  } fan_t;

  // seven-step map of (set point - temperature) to duty and percent
  function automatic fan_t fan_lookup(input logic [TEMP_W-1:0] sp,
                                      input logic [TEMP_W-1:0] temp);
    logic signed [TEMP_W:0] d;
    fan_t f;
    d = $signed({1'b0, sp}) - $signed({1'b0, temp});
    if (d <= -7'sd3) begin
      f.duty = 8'd255; f.pct = 7'd100;
    end else if (d == -7'sd2) begin
      f.duty = 8'd230; f.pct = 7'd90;
    end else if (d == -7'sd1) begin
      f.duty = 8'd210; f.pct = 7'd82;
    end else if (d == 7'sd0) begin
      f.duty = 8'd190; f.pct = 7'd74;
    end else if (d == 7'sd1) begin
      f.duty = 8'd140; f.pct = 7'd54;
    end else if (d == 7'sd2) begin
      f.duty = 8'd120; f.pct = 7'd47;
    end else begin
      f.duty = 8'd0;   f.pct = 7'd0;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

[src/ofsc_in_if.sv]
`default_nettype none

interface ofsc_in_if;
  logic                             valid;
  logic                             ready;
  logic [ofsc_pkg::LIGHT_BITS-1:0]  light_level;
  logic                             motion;
  logic [ofsc_pkg::TEMP_W-1:0]      temperature;
  logic [1:0]                       opcode;

  modport source (output valid, light_level, motion, temperature, opcode, input ready);
  modport sink   (input valid, light_level, motion, temperature, opcode, output ready);
endinterface

`default_nettype wire

[src/ofsc_out_if.sv]
`default_nettype none

interface ofsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ofsc_pkg::DUTY_W-1:0]  pwm_duty;
  logic [ofsc_pkg::PCT_W-1:0]   fan_percent;
  logic [1:0]                   power_mode;
  logic [ofsc_pkg::TEMP_W-1:0]  set_point_out;

  modport source (output valid, pwm_duty, fan_percent, power_mode, set_point_out,
                  input ready);
  modport sink   (input valid, pwm_duty, fan_percent, power_mode, set_point_out,
                  output ready);
endinterface

`default_nettype wire

[src/occupancy_fan_speed_controller_core.sv]
// Occupancy-gated fan speed controller.
// in_if carries one sensor tick per beat: light level, motion bit, room
// temperature and a remote button code. out_if returns one beat per tick with
// the fan PWM duty, fan percent, power mode and current set point as they
// stand after that tick.
// A tick accepted is held in the input register; when it advances, the
// controller state, which doubles as the result register, is updated from it
// and the result becomes valid. While the receiver takes results, throughput
// is one tick per cycle: the input register refills in the same cycle its
// tick moves on, and the state update is a single pass of logic.
// When the receiver stalls, the result holds, one more tick waits in the
// input register, and in_if.ready drops until out_if.ready returns.
// Reset (rst_n low at a clock edge) empties both stages and returns the
// controller to waiting for motion, zero duty, set point 20, idle limit 800.
// The idle limit register sits at byte address 0 of the APB port; write it
// only while no tick is in flight.
`default_nettype none
`include "assert_macros.svh"

module occupancy_fan_speed_controller_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  ofsc_in_if.sink                             in_if,
  ofsc_out_if.source                          out_if,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [ofsc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire  [ofsc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ofsc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // configuration
  logic [ofsc_pkg::LIMIT_W-1:0] idle_limit_r;
  logic                         cfg_wr;

  // input register
  logic                            s1_valid_r;
  logic [ofsc_pkg::LIGHT_BITS-1:0] s1_light_r;
  logic                            s1_motion_r;
  logic [ofsc_pkg::TEMP_W-1:0]     s1_temp_r;
  ofsc_pkg::op_t                   s1_op_r;

  // controller state, also the result register
  logic                         out_valid_r;
  ofsc_pkg::mode_t              mode_r, mode_nxt;
  logic                         permit_r, permit_nxt;
  logic [ofsc_pkg::LIMIT_W-1:0] idle_r, idle_nxt;
  logic [ofsc_pkg::DUTY_W-1:0]  duty_r, duty_nxt;
  logic [ofsc_pkg::PCT_W-1:0]   pct_r, pct_nxt;
  logic [ofsc_pkg::TEMP_W-1:0]  sp_r, sp_nxt;

  logic          adv;
  ofsc_pkg::fan_t fan;
  logic          lit;
  logic          dark;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[ofsc_pkg::CFG_ADDR_W-1] == ofsc_pkg::REG_IDLE_LIMIT);

  always_comb begin
    prdata = '0;
    if (paddr[ofsc_pkg::CFG_ADDR_W-1] == ofsc_pkg::REG_IDLE_LIMIT) begin
      prdata[ofsc_pkg::LIMIT_W-1:0] = idle_limit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r <= ofsc_pkg::IDLE_LIMIT_RST;
    end else if (cfg_wr) begin
      idle_limit_r <= pwdata[ofsc_pkg::LIMIT_W-1:0];
    end
  end

  // advance the held tick whenever the result slot is free or being taken
  assign adv         = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_light_r  <= in_if.light_level;
      s1_motion_r <= in_if.motion;
      s1_temp_r   <= in_if.temperature;
      s1_op_r     <= ofsc_pkg::op_t'(in_if.opcode);
    end
  end

  assign fan  = ofsc_pkg::fan_lookup(sp_nxt, s1_temp_r);
  assign lit  = (s1_light_r > ofsc_pkg::LIGHT_BITS'(1));
  assign dark = (s1_light_r == '0);

  // single-pass tick update; the table reads the set point after any button
  always_comb begin
    mode_nxt   = mode_r;
    permit_nxt = permit_r;
    idle_nxt   = idle_r;
    duty_nxt   = duty_r;
    pct_nxt    = pct_r;
    sp_nxt     = sp_r;

    case (s1_op_r)
      ofsc_pkg::OP_RAISE: if (sp_r != ofsc_pkg::SET_POINT_MAX) sp_nxt = sp_r + 1'b1;
      ofsc_pkg::OP_LOWER: if (sp_r != '0) sp_nxt = sp_r - 1'b1;
      default: ;
    endcase

    if (lit) begin
      if (idle_nxt != ofsc_pkg::IDLE_MAX) begin
        idle_nxt = idle_nxt + 1'b1;
      end
      if (s1_motion_r && mode_nxt == ofsc_pkg::MODE_WAIT) begin
        mode_nxt   = ofsc_pkg::MODE_RUN;
        permit_nxt = 1'b1;
        idle_nxt   = '0;
        duty_nxt   = fan.duty;
        pct_nxt    = fan.pct;
      end else if (mode_nxt == ofsc_pkg::MODE_WAIT) begin
        idle_nxt = '0;
      end else if (mode_nxt == ofsc_pkg::MODE_RUN && duty_nxt != '0 && permit_nxt) begin
        duty_nxt = fan.duty;
        pct_nxt  = fan.pct;
        if (s1_motion_r) begin
          idle_nxt = '0;
        end else if (idle_nxt >= idle_limit_r) begin
          mode_nxt   = ofsc_pkg::MODE_WAIT;
          duty_nxt   = '0;
          pct_nxt    = '0;
          idle_nxt   = '0;
          permit_nxt = 1'b0;
        end
      end
      if (s1_motion_r && duty_nxt == '0) begin
        duty_nxt   = fan.duty;
        pct_nxt    = fan.pct;
        mode_nxt   = ofsc_pkg::MODE_RUN;
        permit_nxt = 1'b1;
      end
    end else if (dark) begin
      mode_nxt   = ofsc_pkg::MODE_WAIT;
      duty_nxt   = '0;
      pct_nxt    = '0;
      idle_nxt   = '0;
      permit_nxt = 1'b0;
    end

    case (s1_op_r)
      ofsc_pkg::OP_RAISE, ofsc_pkg::OP_LOWER: begin
        duty_nxt = fan.duty;
        pct_nxt  = fan.pct;
      end
      ofsc_pkg::OP_OFF: begin
        mode_nxt   = ofsc_pkg::MODE_OFF;
        duty_nxt   = '0;
        pct_nxt    = '0;
        permit_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= ofsc_pkg::MODE_WAIT;
      permit_r    <= 1'b0;
      idle_r      <= '0;
      duty_r      <= '0;
      pct_r       <= '0;
      sp_r        <= ofsc_pkg::SET_POINT_RST;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        permit_r    <= permit_nxt;
        idle_r      <= idle_nxt;
        duty_r      <= duty_nxt;
        pct_r       <= pct_nxt;
        sp_r        <= sp_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.pwm_duty      = duty_r;
  assign out_if.fan_percent   = pct_r;
  assign out_if.power_mode    = mode_r;
  assign out_if.set_point_out = sp_r;

  `ASSERT_ALWAYS(a_wait_no_permit, !(mode_r == ofsc_pkg::MODE_WAIT && permit_r), "permit set while waiting")
  `ASSERT_ALWAYS(a_duty_pct_pair, (duty_r == '0) == (pct_r == '0), "duty and percent disagree on zero")
  `ASSERT_IMPLY(a_stall_holds, out_valid_r && !out_if.ready, out_valid_r && $stable(duty_r) && $stable(sp_r) && $stable(mode_r), "result changed under stall")
  `ASSERT_IMPLY(a_idle_frozen, !adv, $stable(idle_r) && $stable(permit_r), "state moved without a tick")
  `ASSERT_IMPLY(a_accept_loads, in_if.valid && in_if.ready, s1_valid_r, "accepted tick not held")

endmodule

`default_nettype wire
